/* rtl/core/vertex_clip_project_unit_assert.svh */
// ----------------------------------------------------------------------------
// Vertex clip project unit assertion macros
// Shared concurrent assertion forms for the checker of the vertex unit.
// ----------------------------------------------------------------------------
`ifndef VERTEX_CLIP_PROJECT_UNIT_ASSERT_SVH
`define VERTEX_CLIP_PROJECT_UNIT_ASSERT_SVH

// The consequent must hold whenever the antecedent holds.
`define VCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex unit check failed");

// The condition must never hold.
`define VCP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("vertex unit check failed");

`endif

/* rtl/core/vcp_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex clip project package
// Constants, register indexes and saturation helpers for the vertex unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcp_pkg;

   localparam int COEF_BITS_DEFAULT  = 16;
   localparam int POS_BITS_DEFAULT   = 16;
   localparam int NEAR_LIMIT_Q16     = 7;
   localparam int INV_BITS           = 30;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = INV_BITS / DIV_BITS_PER_STAGE;
   localparam int LATENCY            = DIV_STAGES + 6;

   typedef enum logic [2:0] {
      CSR_MATRIX_ROW_0  = 3'd0,
      CSR_MATRIX_ROW_1  = 3'd1,
      CSR_MATRIX_ROW_2  = 3'd2,
      CSR_MATRIX_ROW_3  = 3'd3,
      CSR_TARGET_WIDTH  = 3'd4,
      CSR_TARGET_HEIGHT = 3'd5
   } csr_index_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) begin
         return 24'sh7fffff;
      end else if (v < -64'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

/* rtl/core/vertex_clip_project_unit.sv */
// ----------------------------------------------------------------------------
// Vertex clip project unit
// Transforms one vertex by the configured matrix, divides by clip w and maps
// the result through the viewport to screen coordinates and depth.
// ----------------------------------------------------------------------------
// A new vertex beat is taken on every clock cycle while busy is low; its result
// appears on the rsp_ ports after passing stage 1, the divider registers and stages 3
// to 6, strobed by rsp_valid for a single cycle. The pipelined reciprocal divider
// resolves two quotient bits in each of its fifteen stages. The receiver cannot
// stall the pipeline, so results must be taken when they are strobed. Busy is
// high only while reset is asserted.
`timescale 1ns / 1ps

module vertex_clip_project_unit import vcp_pkg::*; #(
   parameter int COEF_BITS = COEF_BITS_DEFAULT,
   parameter int POS_BITS  = POS_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [15:0]                req_vertex_index,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   input  logic                       csr_write_enable,
   input  logic [2:0]                 csr_index,
   input  logic [63:0]                csr_write_data,
   output logic                       rsp_valid,
   output logic [15:0]                rsp_slot_index,
   output logic signed [31:0]         rsp_clip_w,
   output logic                       rsp_behind_near,
   output logic [29:0]                rsp_inv_w,
   output logic signed [23:0]         rsp_screen_x,
   output logic signed [23:0]         rsp_screen_y,
   output logic signed [15:0]         rsp_depth
);

   localparam int PROD_W = COEF_BITS + POS_BITS;
   localparam int ACC_W  = PROD_W + 2;
   localparam int ROW_W  = 4 * COEF_BITS;

   localparam logic signed [ACC_W-1:0] CLIP_HALF = ACC_W'(8);
   localparam logic signed [62:0] NX_BIAS   = 63'sh1_0000_8000;
   localparam logic signed [62:0] HALF_Q16  = 63'sh8000;
   localparam logic signed [62:0] HALF_Q20  = 63'sh8_0000;
   localparam logic signed [46:0] ONE_Q16   = 47'sd65536;
   localparam logic signed [60:0] HALF_Q13  = 61'sd4096;

   typedef struct packed {
      logic               valid;
      logic [15:0]        index;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] cw;
      logic               behind;
      logic [30:0]        divisor;
      logic [30:0]        rem;
      logic [29:0]        num;
      logic [29:0]        quo;
   } div_stage_type;

   // Configuration registers.
   logic [63:0] matrix_ff [4];
   logic [12:0] width_ff;
   logic [12:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            matrix_ff[r] <= '0;
         end
         width_ff  <= 13'd320;
         height_ff <= 13'd240;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MATRIX_ROW_0:  matrix_ff[0] <= csr_write_data;
            CSR_MATRIX_ROW_1:  matrix_ff[1] <= csr_write_data;
            CSR_MATRIX_ROW_2:  matrix_ff[2] <= csr_write_data;
            CSR_MATRIX_ROW_3:  matrix_ff[3] <= csr_write_data;
            CSR_TARGET_WIDTH:  width_ff     <= csr_write_data[12:0];
            CSR_TARGET_HEIGHT: height_ff    <= csr_write_data[12:0];
            default: begin
            end
         endcase
      end
   end

   assign busy = reset;

   // Coefficient lanes; lanes past the register top read as zero.
   logic [ROW_W+63:0]           row_ext [4];
   logic signed [COEF_BITS-1:0] coef [4][4];
   logic signed [POS_BITS-1:0]  pos [3];

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_ext[r] = {{ROW_W{1'b0}}, matrix_ff[r]};
         for (int k = 0; k < 4; k++) begin
            coef[r][k] = row_ext[r][k*COEF_BITS +: COEF_BITS];
         end
      end
   end

   // Stage 1: coefficient products.
   logic                        s1_valid_ff;
   logic [15:0]                 s1_index_ff;
   logic signed [PROD_W-1:0]    s1_prod_ff [4][3];
   logic signed [COEF_BITS-1:0] s1_c3_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_index_ff <= req_vertex_index;
      for (int r = 0; r < 4; r++) begin
         s1_c3_ff[r] <= coef[r][3];
         for (int k = 0; k < 3; k++) begin
            s1_prod_ff[r][k] <= coef[r][k] * pos[k];
         end
      end
   end

   // Stage 2: row sums, rounding to Q.16 and divider setup.
   logic signed [ACC_W-1:0] acc_in [4];
   logic signed [ACC_W-1:0] rnd_in [4];
   logic signed [31:0]      clip_in [4];
   logic                    behind_in;
   logic [30:0]             divisor_in;
   logic [32:0]             numer_in;
   div_stage_type           div_ff [DIV_STAGES+1];
   div_stage_type           div_in [DIV_STAGES+1];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         acc_in[r] = (ACC_W'(s1_c3_ff[r]) <<< 8) + ACC_W'(s1_prod_ff[r][0])
                   + ACC_W'(s1_prod_ff[r][1]) + ACC_W'(s1_prod_ff[r][2]);
         rnd_in[r] = (acc_in[r] + CLIP_HALF) >>> 4;
         clip_in[r] = sat32(64'(rnd_in[r]));
      end
      behind_in  = clip_in[3] <= 32'sd7;
      divisor_in = behind_in ? 31'd8 : clip_in[3][30:0];
      numer_in   = 33'h1_0000_0000 + {3'b000, divisor_in[30:1]};
      div_in[0].valid   = s1_valid_ff;
      div_in[0].index   = s1_index_ff;
      div_in[0].cx      = clip_in[0];
      div_in[0].cy      = clip_in[1];
      div_in[0].cz      = clip_in[2];
      div_in[0].cw      = clip_in[3];
      div_in[0].behind  = behind_in;
      div_in[0].divisor = divisor_in;
      div_in[0].rem     = {28'd0, numer_in[32:30]};
      div_in[0].num     = numer_in[29:0];
      div_in[0].quo     = '0;
   end

   // Reciprocal divider: restoring steps, two quotient bits per stage.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      always_comb begin : step
         div_stage_type st;
         logic [31:0]   trial;
         st = div_ff[s];
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            trial  = {st.rem, st.num[29]};
            st.num = {st.num[28:0], 1'b0};
            if (trial >= {1'b0, st.divisor}) begin
               st.rem = 31'(trial - {1'b0, st.divisor});
               st.quo = {st.quo[28:0], 1'b1};
            end else begin
               st.rem = trial[30:0];
               st.quo = {st.quo[28:0], 1'b0};
            end
         end
         div_in[s+1] = st;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
         if (reset) begin
            div_ff[i] <= '0;
         end else begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   // Stage 3: clip times reciprocal.
   logic               s3_valid_ff;
   logic [15:0]        s3_index_ff;
   logic signed [31:0] s3_cw_ff;
   logic               s3_behind_ff;
   logic [29:0]        s3_inv_ff;
   logic signed [61:0] s3_px_ff;
   logic signed [61:0] s3_py_ff;
   logic signed [61:0] s3_pz_ff;
   logic [29:0]        inv_in;
   logic signed [30:0] inv_s_in;

   assign inv_in   = div_ff[DIV_STAGES].behind ? 30'd0 : div_ff[DIV_STAGES].quo;
   assign inv_s_in = signed'({1'b0, inv_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= div_ff[DIV_STAGES].valid;
      end
      s3_index_ff  <= div_ff[DIV_STAGES].index;
      s3_cw_ff     <= div_ff[DIV_STAGES].cw;
      s3_behind_ff <= div_ff[DIV_STAGES].behind;
      s3_inv_ff    <= inv_in;
      s3_px_ff     <= div_ff[DIV_STAGES].cx * inv_s_in;
      s3_py_ff     <= div_ff[DIV_STAGES].cy * inv_s_in;
      s3_pz_ff     <= div_ff[DIV_STAGES].cz * inv_s_in;
   end

   // Stage 4: normalized device coordinates and depth.
   logic               s4_valid_ff;
   logic [15:0]        s4_index_ff;
   logic signed [31:0] s4_cw_ff;
   logic               s4_behind_ff;
   logic [29:0]        s4_inv_ff;
   logic signed [46:0] s4_nxp_ff;
   logic signed [46:0] s4_nyn_ff;
   logic signed [15:0] s4_dz_ff;
   logic signed [62:0] nx_sum_in;
   logic signed [62:0] ny_sum_in;
   logic signed [62:0] dz_sum_in;
   logic signed [62:0] ny_in;

   always_comb begin
      nx_sum_in = (63'(s3_px_ff) + NX_BIAS) >>> 16;
      ny_sum_in = (63'(s3_py_ff) + HALF_Q16) >>> 16;
      dz_sum_in = (63'(s3_pz_ff) + HALF_Q20) >>> 20;
      ny_in     = ny_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_index_ff  <= s3_index_ff;
      s4_cw_ff     <= s3_cw_ff;
      s4_behind_ff <= s3_behind_ff;
      s4_inv_ff    <= s3_inv_ff;
      s4_nxp_ff    <= nx_sum_in[46:0];
      s4_nyn_ff    <= ONE_Q16 - ny_in[46:0];
      s4_dz_ff     <= sat16(64'(dz_sum_in));
   end

   // Stage 5: viewport scaling.
   logic               s5_valid_ff;
   logic [15:0]        s5_index_ff;
   logic signed [31:0] s5_cw_ff;
   logic               s5_behind_ff;
   logic [29:0]        s5_inv_ff;
   logic signed [15:0] s5_dz_ff;
   logic signed [60:0] s5_sx_ff;
   logic signed [60:0] s5_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_index_ff  <= s4_index_ff;
      s5_cw_ff     <= s4_cw_ff;
      s5_behind_ff <= s4_behind_ff;
      s5_inv_ff    <= s4_inv_ff;
      s5_dz_ff     <= s4_dz_ff;
      s5_sx_ff     <= s4_nxp_ff * signed'({1'b0, width_ff});
      s5_sy_ff     <= s4_nyn_ff * signed'({1'b0, height_ff});
   end

   // Stage 6: rounding to Q.4 and the output register.
   logic               rsp_valid_ff;
   logic [15:0]        rsp_index_ff;
   logic signed [31:0] rsp_cw_ff;
   logic               rsp_behind_ff;
   logic [29:0]        rsp_inv_ff;
   logic signed [23:0] rsp_sx_ff;
   logic signed [23:0] rsp_sy_ff;
   logic signed [15:0] rsp_dz_ff;
   logic signed [60:0] sx_rnd_in;
   logic signed [60:0] sy_rnd_in;

   always_comb begin
      sx_rnd_in = (s5_sx_ff + HALF_Q13) >>> 13;
      sy_rnd_in = (s5_sy_ff + HALF_Q13) >>> 13;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s5_valid_ff;
      end
      rsp_index_ff  <= s5_index_ff;
      rsp_cw_ff     <= s5_cw_ff;
      rsp_behind_ff <= s5_behind_ff;
      rsp_inv_ff    <= s5_inv_ff;
      rsp_dz_ff     <= s5_dz_ff;
      rsp_sx_ff     <= sat24(64'(sx_rnd_in));
      rsp_sy_ff     <= sat24(64'(sy_rnd_in));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_clip_w      = rsp_cw_ff;
   assign rsp_behind_near = rsp_behind_ff;
   assign rsp_inv_w       = rsp_inv_ff;
   assign rsp_screen_x    = rsp_sx_ff;
   assign rsp_screen_y    = rsp_sy_ff;
   assign rsp_depth       = rsp_dz_ff;

endmodule

/* rtl/core/vcp_checker.sv */
// ----------------------------------------------------------------------------
// Vertex clip project checker
// Port-level checks of the vertex unit, bound to the vertex unit module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vertex_clip_project_unit_assert.svh"

module vcp_checker import vcp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [15:0]        req_vertex_index,
   input logic               rsp_valid,
   input logic [15:0]        rsp_slot_index,
   input logic signed [31:0] rsp_clip_w,
   input logic               rsp_behind_near,
   input logic [29:0]        rsp_inv_w
);

   // Every result beat comes from an accepted vertex beat and carries that beat's index.
   `VCP_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   `VCP_ASSERT_IMPL(a_slot_echo, clock, reset, rsp_valid, rsp_slot_index == $past(req_vertex_index, LATENCY))
   `VCP_ASSERT_NEVER(a_behind_inv, clock, reset, rsp_valid && rsp_behind_near && rsp_inv_w != 30'd0)
   `VCP_ASSERT_IMPL(a_front_w, clock, reset, rsp_valid && !rsp_behind_near, rsp_clip_w > 32'sd7 && rsp_inv_w != 30'd0)

endmodule

bind vertex_clip_project_unit vcp_checker u_vcp_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Vertex clip project unit testbench
// Drives vertex beats through the unit under several matrix and viewport
// settings and checks every result against a cycle-free prediction of the
// transform, reciprocal, viewport mapping and depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import vcp_pkg::*;

   localparam int          STALL_LIMIT    = 500;
   localparam logic [2:0]  CSR_SPARE_6    = 3'd6;
   localparam logic [2:0]  CSR_SPARE_7    = 3'd7;

   typedef struct {
      logic [15:0]        slot;
      logic signed [31:0] clip_w;
      logic               behind;
      logic [29:0]        inv_w;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic signed [15:0] depth;
   } vertex_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [15:0]        req_vertex_index;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic signed [15:0] req_pos_z;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [63:0]        csr_write_data;
   logic               rsp_valid;
   logic [15:0]        rsp_slot_index;
   logic signed [31:0] rsp_clip_w;
   logic               rsp_behind_near;
   logic [29:0]        rsp_inv_w;
   logic signed [23:0] rsp_screen_x;
   logic signed [23:0] rsp_screen_y;
   logic signed [15:0] rsp_depth;

   logic [63:0]       mvp_row [4];
   logic [12:0]       view_width;
   logic [12:0]       view_height;
   vertex_result_type pending_vertices [$];
   int                error_count;
   int                stall_cycles;
   int                send_idle_pct;

   vertex_clip_project_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_clip_w       (rsp_clip_w),
      .rsp_behind_near  (rsp_behind_near),
      .rsp_inv_w        (rsp_inv_w),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .rsp_depth        (rsp_depth)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint coef_lane(logic [63:0] row, int k);
      return longint'($signed(row[k*16 +: 16]));
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint clip_coord(logic [63:0] row, longint px, longint py, longint pz);
      longint acc;
      acc = coef_lane(row, 3) * 256 + coef_lane(row, 0) * px + coef_lane(row, 1) * py
            + coef_lane(row, 2) * pz;
      return clamp(round_shift(acc, 4), 32);
   endfunction

   function automatic vertex_result_type project_vertex(logic [15:0] idx,
                                                        logic signed [15:0] x,
                                                        logic signed [15:0] y,
                                                        logic signed [15:0] z);
      vertex_result_type r;
      longint cx, cy, cz, cw, inv, nx, ny;
      cx = clip_coord(mvp_row[0], x, y, z);
      cy = clip_coord(mvp_row[1], x, y, z);
      cz = clip_coord(mvp_row[2], x, y, z);
      cw = clip_coord(mvp_row[3], x, y, z);
      r.behind = (cw <= NEAR_LIMIT_Q16);
      if (r.behind) begin
         inv = 0;
      end else begin
         inv = clamp(((64'sd1 <<< 32) + cw / 2) / cw, 31);
      end
      if (inv > 64'h3FFFFFFF) begin
         inv = 64'h3FFFFFFF;
      end
      nx = round_shift(cx * inv, 16);
      ny = round_shift(cy * inv, 16);
      r.slot   = idx;
      r.clip_w = cw[31:0];
      r.inv_w  = inv[29:0];
      r.sx     = 24'(clamp(round_shift((nx + 65536) * longint'(view_width), 13), 24));
      r.sy     = 24'(clamp(round_shift((65536 - ny) * longint'(view_height), 13), 24));
      r.depth  = 16'(clamp(round_shift(cz * inv, 20), 16));
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      vertex_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_vertices.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat, expected none, actual slot %0h",
                     $time, rsp_slot_index);
         end else begin
            e = pending_vertices.pop_front();
            check_field("slot_index", e.slot, rsp_slot_index);
            check_field("clip_w", e.clip_w, rsp_clip_w);
            check_field("behind_near", e.behind, rsp_behind_near);
            check_field("inv_w", e.inv_w, rsp_inv_w);
            check_field("screen_x", e.sx, rsp_screen_x);
            check_field("screen_y", e.sy, rsp_screen_y);
            check_field("depth", e.depth, rsp_depth);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_vertex(logic [15:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_vertex_index <= idx;
      req_pos_x        <= x;
      req_pos_y        <= y;
      req_pos_z        <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_vertices.push_back(project_vertex(idx, x, y, z));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_config(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [63:0] w, logic [63:0] h);
      logic [63:0] vals [6];
      csr_index_type idx [6];
      vals = '{r0, r1, r2, r3, w, h};
      idx  = '{CSR_MATRIX_ROW_0, CSR_MATRIX_ROW_1, CSR_MATRIX_ROW_2, CSR_MATRIX_ROW_3,
               CSR_TARGET_WIDTH, CSR_TARGET_HEIGHT};
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= vals[i];
         @(posedge clock);
         if (i < 4) begin
            mvp_row[i] = vals[i];
         end else if (i == 4) begin
            view_width = vals[i][12:0];
         end else begin
            view_height = vals[i][12:0];
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [63:0] pack_row(int c0, int c1, int c2, int c3);
      return {c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
   endfunction

   function automatic logic [63:0] random_row(bit is_w);
      int c [4];
      if ($urandom_range(9) == 0) begin
         return {$urandom, $urandom};
      end
      for (int k = 0; k < 4; k++) begin
         c[k] = int'($urandom_range(0, 8191)) - 4096;
      end
      if (is_w) begin
         c[3] = $urandom_range(4096, 32767);
      end
      return pack_row(c[0], c[1], c[2], c[3]);
   endfunction

   function automatic logic [12:0] random_size();
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'h1FFF;
         3: return 13'd1;
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic test_reset_state();
      send_vertex(16'h0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_vertex(16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh1234);
      drain_results();
   endtask

   task automatic test_identity_transform();
      set_config(pack_row(4096, 0, 0, 0), pack_row(0, 4096, 0, 0), pack_row(0, 0, 4096, 0),
                 pack_row(0, 0, 0, 4096), 320, 240);
      send_vertex(16'h0001, 16'sh0000, 16'sh0000, 16'sh0000);
      send_vertex(16'h0002, 16'sh0100, 16'shFF00, 16'sh0080);
      send_vertex(16'h0003, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_vertex(16'h0004, 16'sh8000, 16'sh8000, 16'sh8000);
      drain_results();
   endtask

   task automatic test_near_plane();
      set_config(pack_row(4096, 0, 0, 0), pack_row(0, 4096, 0, 0), pack_row(0, 0, 4096, 0),
                 pack_row(0, 0, 1, 0), 640, 480);
      send_vertex(16'h0010, 16'sh0100, 16'sh0100, 16'sh0070);
      send_vertex(16'h0011, 16'sh0100, 16'sh0100, 16'sh0080);
      send_vertex(16'h0012, 16'sh0100, 16'sh0100, 16'sh0000);
      send_vertex(16'h0013, 16'sh0100, 16'sh0100, -16'sh0100);
      send_vertex(16'h0014, 16'sh0100, 16'sh0100, 16'sh7FFF);
      drain_results();
   endtask

   task automatic test_saturation();
      set_config(pack_row(32767, 32767, 32767, 32767), pack_row(-32768, -32768, -32768, -32768),
                 pack_row(32767, -32768, 32767, -32768), pack_row(1, 0, 0, 0), 4096, 4096);
      send_vertex(16'h0020, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_vertex(16'h0021, 16'sh0080, 16'sh8000, 16'sh8000);
      send_vertex(16'h0022, 16'sh0090, 16'sh7FFF, 16'sh8000);
      drain_results();
   endtask

   task automatic test_viewport_sizes();
      set_config(pack_row(2048, 0, 0, 0), pack_row(0, 2048, 0, 0), pack_row(0, 0, 2048, 100),
                 pack_row(0, 0, 0, 4096), 0, 13'h1FFF);
      send_vertex(16'h0030, 16'sh0200, -16'sh0200, 16'sh0100);
      send_vertex(16'h0031, -16'sh0100, 16'sh0300, 16'sh0000);
      drain_results();
      set_config(pack_row(2048, 0, 0, 0), pack_row(0, 2048, 0, 0), pack_row(0, 0, 2048, 100),
                 pack_row(0, 0, 0, 4096), 1, 4096);
      send_vertex(16'h0032, 16'sh0200, -16'sh0200, 16'sh0100);
      send_vertex(16'h0033, 16'sh7FFF, 16'sh8000, 16'sh0000);
      drain_results();
   endtask

   task automatic test_unused_index();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SPARE_6;
      csr_write_data   <= '1;
      @(posedge clock);
      csr_index        <= CSR_SPARE_7;
      csr_write_data   <= 64'h0;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      send_vertex(16'h0040, 16'sh0200, -16'sh0200, 16'sh0100);
      drain_results();
   endtask

   task automatic test_random_stream(int idle_pct, int count);
      send_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            drain_results();
            set_config(random_row(0), random_row(0), random_row(0), random_row(1),
                       random_size(), random_size());
         end
         send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      drain_results();
   endtask

   initial begin
      error_count      = 0;
      stall_cycles     = 0;
      send_idle_pct    = 22;
      mvp_row          = '{64'h0, 64'h0, 64'h0, 64'h0};
      view_width       = 13'd320;
      view_height      = 13'd240;
      reset            = 1'b1;
      start            = 1'b0;
      req_vertex_index = '0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_identity_transform();
      test_near_plane();
      test_saturation();
      test_viewport_sizes();
      test_unused_index();
      test_random_stream(22, 200);
      test_random_stream(58, 200);
      test_random_stream(0, 200);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/vcp_pkg.sv
rtl/core/vertex_clip_project_unit.sv
rtl/core/vcp_checker.sv
sim/tb.sv
